// ----- rtl/pctl_pkg.sv -----
// ----------------------------------------------------------------------------
// pctl_pkg: shared types and constants of the PID controller
// Beat payloads, register map, pipeline snapshot and 32-bit saturation.
// ----------------------------------------------------------------------------
package pctl_pkg;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [2:0] REG_SETPOINT     = 3'd0;
   localparam logic [2:0] REG_GAIN_P       = 3'd1;
   localparam logic [2:0] REG_GAIN_I       = 3'd2;
   localparam logic [2:0] REG_GAIN_D       = 3'd3;
   localparam logic [2:0] REG_STEP_TIME    = 3'd4;
   localparam logic [2:0] REG_INV_STEP     = 3'd5;
   localparam logic [2:0] REG_STEP_TICKS   = 3'd6;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic signed [31:0] CTL_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] CTL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [31:0] control;
      logic               saturated;
      logic               updated;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic [15:0]        step_time;
      logic [15:0]        inverse_step_time;
      logic [15:0]        step_ticks;
   } cfg_type;

   // loop state as seen right after one beat's update
   typedef struct packed {
      logic               tick;
      logic signed [16:0] error;
      logic signed [31:0] integral;
      logic signed [31:0] derivative;
      logic               clipped;
      logic               updated;
   } snap_type;

   function automatic logic sat_hit(input logic signed [43:0] v);
      sat_hit = (v > 44'(CTL_MAX)) || (v < 44'(CTL_MIN));
   endfunction

   function automatic logic signed [31:0] sat_value(input logic signed [43:0] v);
      if (v > 44'(CTL_MAX)) begin
         sat_value = CTL_MAX;
      end else if (v < 44'(CTL_MIN)) begin
         sat_value = CTL_MIN;
      end else begin
         sat_value = v[31:0];
      end
   endfunction

endpackage

// ----- rtl/pctl_csr.sv -----
// ----------------------------------------------------------------------------
// pctl_csr: configuration registers
// APB-style register file holding setpoint, gains and timing settings.
// ----------------------------------------------------------------------------
module pctl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pctl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output pctl_pkg::cfg_type                  cfg
);
   import pctl_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SETPOINT:   cfg_in.setpoint          = pwdata[15:0];
            REG_GAIN_P:     cfg_in.gain_p            = pwdata[15:0];
            REG_GAIN_I:     cfg_in.gain_i            = pwdata[15:0];
            REG_GAIN_D:     cfg_in.gain_d            = pwdata[15:0];
            REG_STEP_TIME:  cfg_in.step_time         = pwdata[15:0];
            REG_INV_STEP:   cfg_in.inverse_step_time = pwdata[15:0];
            REG_STEP_TICKS: cfg_in.step_ticks        = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SETPOINT:   prdata = {16'd0, cfg_ff.setpoint};
         REG_GAIN_P:     prdata = {16'd0, cfg_ff.gain_p};
         REG_GAIN_I:     prdata = {16'd0, cfg_ff.gain_i};
         REG_GAIN_D:     prdata = {16'd0, cfg_ff.gain_d};
         REG_STEP_TIME:  prdata = {16'd0, cfg_ff.step_time};
         REG_INV_STEP:   prdata = {16'd0, cfg_ff.inverse_step_time};
         REG_STEP_TICKS: prdata = {16'd0, cfg_ff.step_ticks};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint          <= 16'sd0;
         cfg_ff.gain_p            <= 16'sd256;
         cfg_ff.gain_i            <= 16'sd0;
         cfg_ff.gain_d            <= 16'sd0;
         cfg_ff.step_time         <= 16'd3277;
         cfg_ff.inverse_step_time <= 16'd5120;
         cfg_ff.step_ticks        <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/pctl_update.sv -----
// ----------------------------------------------------------------------------
// pctl_update: input register and loop state update
// Holds the error, integral, derivative and tick count; emits a snapshot.
// ----------------------------------------------------------------------------
module pctl_update (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_in,
   input  logic                 load_snap,
   input  pctl_pkg::req_type    req_data,
   input  pctl_pkg::cfg_type    cfg,
   output pctl_pkg::snap_type   snap
);
   import pctl_pkg::*;

   req_type            item_ff;
   snap_type           snap_ff;
   snap_type           snap_in;

   logic signed [16:0] cur_err_ff;
   logic signed [16:0] cur_err_in;
   logic signed [16:0] prev_err_ff;
   logic signed [16:0] prev_err_in;
   logic signed [31:0] integral_ff;
   logic signed [31:0] integral_in;
   logic signed [31:0] deriv_ff;
   logic signed [31:0] deriv_in;
   logic [15:0]        tick_ff;
   logic [15:0]        tick_in;

   logic [15:0]        limit;
   logic               hit;
   logic signed [33:0] integ_prod;
   logic signed [43:0] integ_sum;
   logic signed [17:0] diff;
   logic signed [34:0] deriv_prod;
   logic signed [43:0] deriv_scaled;

   assign snap = snap_ff;

   always_comb begin
      limit        = (cfg.step_ticks == 16'd0) ? 16'd1 : cfg.step_ticks;
      hit          = ({1'b0, tick_ff} + 17'd1) >= {1'b0, limit};
      integ_prod   = cur_err_ff * $signed({1'b0, cfg.step_time});
      integ_sum    = 44'(integral_ff) + 44'(integ_prod);
      diff         = 18'(cur_err_ff) - 18'(prev_err_ff);
      deriv_prod   = diff * $signed({1'b0, cfg.inverse_step_time});
      deriv_scaled = 44'(deriv_prod) <<< 8;

      cur_err_in  = cur_err_ff;
      prev_err_in = prev_err_ff;
      integral_in = integral_ff;
      deriv_in    = deriv_ff;
      tick_in     = tick_ff;
      snap_in.clipped = 1'b0;
      snap_in.updated = 1'b0;

      if (item_ff.operation == OP_SAMPLE) begin
         cur_err_in = 17'(cfg.setpoint) - 17'(item_ff.measured);
      end else if (hit) begin
         integral_in     = sat_value(integ_sum);
         deriv_in        = sat_value(deriv_scaled);
         prev_err_in     = cur_err_ff;
         tick_in         = 16'd0;
         snap_in.clipped = sat_hit(integ_sum) || sat_hit(deriv_scaled);
         snap_in.updated = 1'b1;
      end else begin
         tick_in = tick_ff + 16'd1;
      end

      snap_in.tick       = (item_ff.operation == OP_TICK);
      snap_in.error      = cur_err_in;
      snap_in.integral   = integral_in;
      snap_in.derivative = deriv_in;
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         item_ff <= req_data;
      end
      if (load_snap) begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_err_ff  <= 17'sd0;
         prev_err_ff <= 17'sd0;
         integral_ff <= 32'sd0;
         deriv_ff    <= 32'sd0;
         tick_ff     <= 16'd0;
      end else if (load_snap) begin
         cur_err_ff  <= cur_err_in;
         prev_err_ff <= prev_err_in;
         integral_ff <= integral_in;
         deriv_ff    <= deriv_in;
         tick_ff     <= tick_in;
      end
   end

endmodule

// ----- rtl/pctl_output.sv -----
// ----------------------------------------------------------------------------
// pctl_output: gain products and control sum
// Multiplies the snapshot by the gains, then sums and saturates the result.
// ----------------------------------------------------------------------------
module pctl_output (
   input  logic                 clock,
   input  logic                 load_prod,
   input  logic                 load_rsp,
   input  pctl_pkg::snap_type   snap,
   input  pctl_pkg::cfg_type    cfg,
   output pctl_pkg::rsp_type    rsp_data
);
   import pctl_pkg::*;

   logic signed [32:0] p_prod_ff;
   logic signed [32:0] p_prod_in;
   logic signed [47:0] i_prod_ff;
   logic signed [47:0] i_prod_in;
   logic signed [47:0] d_prod_ff;
   logic signed [47:0] d_prod_in;
   logic               clip_ff;
   logic               upd_ff;

   logic signed [43:0] ctl_sum;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   assign rsp_data = rsp_ff;

   always_comb begin
      p_prod_in = cfg.gain_p * snap.error;
      i_prod_in = cfg.gain_i * snap.integral;
      d_prod_in = cfg.gain_d * snap.derivative;
   end

   // proportional term is Q.8, the others Q.24: bring all to Q16.16
   always_comb begin
      ctl_sum = (44'(p_prod_ff) <<< 8) + 44'(i_prod_ff >>> 8) + 44'(d_prod_ff >>> 8);
      rsp_in.control   = sat_value(ctl_sum);
      rsp_in.saturated = clip_ff || sat_hit(ctl_sum);
      rsp_in.updated   = upd_ff;
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
         clip_ff   <= snap.clipped;
         upd_ff    <= snap.updated;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/pid_controller_timed_core.sv -----
// ----------------------------------------------------------------------------
// pid_controller_timed_core: fixed-point PID controller with tick timing
// Top level: register port, four-stage beat pipeline and handshake control.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one beat per item. operation 0 is a measurement sample that
//   sets error = setpoint - measured; operation 1 is a timer tick, and every
//   step_ticks ticks updates the integral and derivative.
//   rsp channel: exactly one beat per req beat, in order, carrying the Q16.16
//   control value, a saturation flag and the update flag.
//   Register port: APB-style, registers at byte addresses 0, 4, ... 24;
//   pready is tied high. Write registers only while the pipeline is empty.
// Pipeline and throughput
//   A req beat passes the input register, state update, gain multipliers,
//   and sum and saturation into the output register. One beat is accepted
//   every cycle while the rsp side does not stall; the rate is set by the
//   state update stage, where the loop state is read and rewritten in the
//   same cycle, so each beat sees the state left by the one before it.
// Reset
//   Synchronous, active high: registers return to their defaults, the loop
//   state clears to zero and the pipeline empties.
// Stalls
//   When rsp_ready is low each stage holds only if the stage after it is
//   full, so bubbles close up and req_ready stays high until all four
//   stages hold a beat.
// ----------------------------------------------------------------------------
module pid_controller_timed_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pctl_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pctl_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pctl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import pctl_pkg::*;

   cfg_type  cfg;
   snap_type snap;

   // stage occupancy
   logic v0_ff, v0_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;

   logic load0, move01, move12, move23;
   logic free0, free1, free2, free3;

   // advance a stage whenever the one after it is empty or emptying
   always_comb begin
      free3  = !v3_ff || rsp_ready;
      move23 = v2_ff && free3;
      free2  = !v2_ff || move23;
      move12 = v1_ff && free2;
      free1  = !v1_ff || move12;
      move01 = v0_ff && free1;
      free0  = !v0_ff || move01;
      load0  = req_valid && free0;

      v0_in = load0  || (v0_ff && !move01);
      v1_in = move01 || (v1_ff && !move12);
      v2_in = move12 || (v2_ff && !move23);
      v3_in = move23 || (v3_ff && !rsp_ready);
   end

   assign req_ready = free0;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   pctl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // state advances exactly once per beat, as it leaves the input register
   pctl_update u_update (
      .clock     (clock),
      .reset     (reset),
      .load_in   (load0),
      .load_snap (move01),
      .req_data  (req_data),
      .cfg       (cfg),
      .snap      (snap)
   );

   pctl_output u_output (
      .clock     (clock),
      .load_prod (move12),
      .load_rsp  (move23),
      .snap      (snap),
      .cfg       (cfg),
      .rsp_data  (rsp_data)
   );

   // a bubble in the input register must open the req side
   a_ready_on_bubble: assert property (@(posedge clock) disable iff (reset)
      !v0_ff |-> req_ready)
      else $error("req_ready low with an empty input register");

   // a beat moved into the output stage must be offered next cycle
   a_output_filled: assert property (@(posedge clock) disable iff (reset)
      move23 |=> rsp_valid)
      else $error("beat lost on the way to the output register");

   // only a tick beat can carry an update
   a_update_on_tick: assert property (@(posedge clock) disable iff (reset)
      v1_ff && snap.updated |-> snap.tick)
      else $error("update flagged on a sample beat");

   // a stalled result beat stays offered
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

endmodule

// ----- tb/tb_pid_controller_timed_core.sv -----
// ----------------------------------------------------------------------------
// tb_pid_controller_timed_core: self-checking bench for the timed PID core
// Drives sample and tick beats through the req channel, programs the loop
// registers over the APB-style port between phases, and compares every rsp
// beat field by field against a cycle-free model of the loop kept here.
// ----------------------------------------------------------------------------
module tb_pid_controller_timed_core;
   import pctl_pkg::*;

   // Address index past the last register; writes there must change nothing.
   localparam logic [2:0] REG_UNMAPPED = 3'd7;
   // Watchdog on the whole run, in clock cycles.
   localparam int unsigned RUN_LIMIT   = 200000;
   // Longest wait for the pipeline to empty at a phase boundary.
   localparam int unsigned DRAIN_LIMIT = 2000;
   // Cycles to let pass once nothing is outstanding (four-stage pipeline).
   localparam int unsigned SETTLE_CYCLES = 8;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   // Shadow copy of the loop registers and loop state.
   cfg_type                 loop_cfg;
   logic signed [16:0]      err_now;
   logic signed [16:0]      err_prev;
   logic signed [31:0]      integ_acc;
   logic signed [31:0]      deriv_val;
   logic [15:0]             tick_cnt;

   rsp_type                 control_due[$];
   int unsigned             mismatch_count = 0;
   int unsigned             cycle_count = 0;
   bit                      idle_on = 1'b0;
   int unsigned             stall_left = 0;

   pid_controller_timed_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: give up if the run overstays its budget.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Mismatch reporting
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Loop model
   // ---------------------------------------------------------------------
   // Clip to the signed 32-bit range and raise the flag on a clip.
   function automatic logic signed [31:0] clip32(input longint v, inout logic hit);
      if (v > longint'(CTL_MAX)) begin
         hit = 1'b1;
         return CTL_MAX;
      end
      if (v < longint'(CTL_MIN)) begin
         hit = 1'b1;
         return CTL_MIN;
      end
      return v[31:0];
   endfunction

   // Advance the shadow loop by one beat and return the control beat it owes.
   function automatic rsp_type pid_step(input req_type beat);
      int unsigned limit;
      longint      diff;
      longint      p_term;
      longint      i_term;
      longint      d_term;
      logic        hit;
      logic        upd;
      rsp_type     r;
      hit = 1'b0;
      upd = 1'b0;
      if (beat.operation == OP_SAMPLE) begin
         err_now = 17'(longint'(loop_cfg.setpoint) - longint'(beat.measured));
      end else begin
         // a step_ticks of zero behaves as one: every tick updates
         limit = (loop_cfg.step_ticks == 16'd0) ? 32'd1 : {16'd0, loop_cfg.step_ticks};
         // fire once count+1 reaches the limit, even if the limit was lowered
         if ({16'd0, tick_cnt} + 32'd1 >= limit) begin
            diff      = longint'(err_now) - longint'(err_prev);
            integ_acc = clip32(longint'(integ_acc)
                               + longint'(err_now) * longint'(loop_cfg.step_time), hit);
            deriv_val = clip32(diff * longint'(loop_cfg.inverse_step_time) * 256, hit);
            err_prev  = err_now;
            tick_cnt  = 16'd0;
            upd       = 1'b1;
         end else begin
            tick_cnt = tick_cnt + 16'd1;
         end
      end
      p_term = longint'(loop_cfg.gain_p) * longint'(err_now) * 256;
      // Q.24 products drop to Q16.16 with a flooring shift
      i_term = (longint'(loop_cfg.gain_i) * longint'(integ_acc)) >>> 8;
      d_term = (longint'(loop_cfg.gain_d) * longint'(deriv_val)) >>> 8;
      r.control   = clip32(p_term + i_term + d_term, hit);
      r.saturated = hit;
      r.updated   = upd;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ---------------------------------------------------------------------
   // Stall rsp_ready in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted rsp beat with the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (control_due.size() == 0) begin
            note_mismatch($sformatf("rsp beat with nothing expected (control %0d)",
                                    rsp_data.control));
         end else begin
            want = control_due.pop_front();
            if (rsp_data.control !== want.control) begin
               note_mismatch($sformatf("control got %0d want %0d",
                                       rsp_data.control, want.control));
            end
            if (rsp_data.saturated !== want.saturated) begin
               note_mismatch($sformatf("saturated got %b want %b",
                                       rsp_data.saturated, want.saturated));
            end
            if (rsp_data.updated !== want.updated) begin
               note_mismatch($sformatf("updated got %b want %b",
                                       rsp_data.updated, want.updated));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side and register port
   // ---------------------------------------------------------------------
   // Present one beat, with an optional idle burst first, and hold it until
   // accepted. Valid stays high afterwards so back-to-back beats stream.
   task automatic send_beat(input logic op, input logic [15:0] measured);
      req_type beat;
      int      gap;
      beat.operation = op;
      beat.measured  = measured;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      control_due.push_back(pid_step(beat));
   endtask

   // Drop valid, wait for every outstanding beat, then let the pipe go quiet.
   // Anything still owed after the wait is reported and discarded.
   task automatic settle_pipeline();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (control_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (control_due.size() != 0) begin
         void'(control_due.pop_front());
         note_mismatch("expected rsp beat never arrived");
      end
   endtask

   // One APB write: setup cycle, then access until pready. Upper data bits
   // are noise; only the low half belongs to any register.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SETPOINT:   loop_cfg.setpoint          = value;
         REG_GAIN_P:     loop_cfg.gain_p            = value;
         REG_GAIN_I:     loop_cfg.gain_i            = value;
         REG_GAIN_D:     loop_cfg.gain_d            = value;
         REG_STEP_TIME:  loop_cfg.step_time         = value;
         REG_INV_STEP:   loop_cfg.inverse_step_time = value;
         REG_STEP_TICKS: loop_cfg.step_ticks        = value;
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random signed value biased towards the extremes and small magnitudes.
   function automatic logic [15:0] pick_signed();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 1023) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Random unsigned value, extremes included.
   function automatic logic [15:0] pick_unsigned();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset values: gain_p 1.0, setpoint 0, 100 ticks per update. A sample of
   // the most negative position drives control exactly one past the top.
   task automatic test_reset_defaults();
      send_beat(OP_SAMPLE, 16'h8000);
      send_beat(OP_TICK,   16'h0000);
      send_beat(OP_SAMPLE, 16'h7fff);
      send_beat(OP_TICK,   16'hffff);
      settle_pipeline();
   endtask

   // Every register at an extreme, step_ticks zero so each tick updates, and
   // an error large enough to clip integral, derivative and control.
   task automatic test_register_extremes();
      write_reg(REG_SETPOINT,   16'h8000);
      write_reg(REG_GAIN_P,     16'h8000);
      write_reg(REG_GAIN_I,     16'h7fff);
      write_reg(REG_GAIN_D,     16'h7fff);
      write_reg(REG_STEP_TIME,  16'hffff);
      write_reg(REG_INV_STEP,   16'hffff);
      write_reg(REG_STEP_TICKS, 16'h0000);
      // unmapped address: must leave the register file alone
      write_reg(REG_UNMAPPED,   16'h1234);
      send_beat(OP_SAMPLE, 16'h7fff);
      send_beat(OP_TICK,   16'h5555);
      send_beat(OP_TICK,   16'haaaa);
      send_beat(OP_SAMPLE, 16'h8000);
      send_beat(OP_TICK,   16'h0000);
      settle_pipeline();
   endtask

   // Run the counter up, then lower step_ticks below it: the next tick must
   // update straight away.
   task automatic test_lowered_tick_limit();
      write_reg(REG_SETPOINT,   16'd100);
      write_reg(REG_GAIN_P,     16'd256);
      write_reg(REG_GAIN_I,     16'd64);
      write_reg(REG_GAIN_D,     16'hff00);
      write_reg(REG_STEP_TIME,  16'd3277);
      write_reg(REG_INV_STEP,   16'd5120);
      write_reg(REG_STEP_TICKS, 16'd6);
      send_beat(OP_SAMPLE, 16'd40);
      repeat (4) send_beat(OP_TICK, 16'd0);
      settle_pipeline();
      write_reg(REG_STEP_TICKS, 16'd2);
      send_beat(OP_TICK,   16'd0);
      send_beat(OP_SAMPLE, 16'hfff0);
      settle_pipeline();
   endtask

   // Random phases: fresh registers each phase, then a stream of mostly
   // ticks and samples near the setpoint. Some phases run without idling,
   // and the last one always does.
   task automatic test_random_traffic();
      logic [15:0] meas;
      logic        op;
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_SETPOINT, pick_signed());
         write_reg(REG_GAIN_P,   pick_signed());
         write_reg(REG_GAIN_I,   pick_signed());
         write_reg(REG_GAIN_D,   pick_signed());
         write_reg(REG_STEP_TIME, pick_unsigned());
         write_reg(REG_INV_STEP,  pick_unsigned());
         // keep updates frequent in most phases; a few take the long limit
         case ($urandom_range(0, 5))
            0: write_reg(REG_STEP_TICKS, 16'h0000);
            1: write_reg(REG_STEP_TICKS, 16'hffff);
            2: write_reg(REG_STEP_TICKS, 16'd1);
            default: write_reg(REG_STEP_TICKS, 16'($urandom_range(2, 12)));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNMAPPED, 16'($urandom));
         end
         idle_on = (ph % 3 != 2) && (ph != 7);
         for (int n = 0; n < 250; n++) begin
            op = ($urandom_range(0, 9) < 6) ? OP_TICK : OP_SAMPLE;
            if ($urandom_range(0, 3) == 0) begin
               meas = 16'($urandom);
            end else begin
               meas = 16'(loop_cfg.setpoint + $urandom_range(0, 64) - 32);
            end
            send_beat(op, meas);
         end
         settle_pipeline();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      // hold every input at a known value from the start
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;

      // shadow starts from the reset values of the block
      loop_cfg.setpoint          = 16'sd0;
      loop_cfg.gain_p            = 16'sd256;
      loop_cfg.gain_i            = 16'sd0;
      loop_cfg.gain_d            = 16'sd0;
      loop_cfg.step_time         = 16'd3277;
      loop_cfg.inverse_step_time = 16'd5120;
      loop_cfg.step_ticks        = 16'd100;
      err_now   = '0;
      err_prev  = '0;
      integ_acc = '0;
      deriv_val = '0;
      tick_cnt  = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      test_reset_defaults();
      test_register_extremes();
      test_lowered_tick_limit();
      test_random_traffic();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
